FILE: rtl/core/dfu_request_state_machine_unit_defines.svh
// Assertion macros shared by the request state machine RTL
`ifndef DFU_REQUEST_STATE_MACHINE_UNIT_DEFINES_SVH
`define DFU_REQUEST_STATE_MACHINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DFURSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define DFURSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dfursm_pkg.sv
// Types, codes and constants of the DFU request state machine
package dfursm_pkg;

    // Firmware transfer size and flash page size in bytes
    localparam int TRANSFER_BYTES = 4096;
    localparam int PAGE_BYTES     = 256;   // power of two, rounding is a mask

    // Widths of the block address arithmetic
    localparam int XFER_W = $clog2(TRANSFER_BYTES + 1);
    localparam int PROD_W = 16 + XFER_W;
    localparam int WA_W   = ((PROD_W > 32) ? PROD_W : 32) + 1;
    localparam int END_W  = WA_W + 1;

    // Block-0 commands
    localparam logic [7:0] CMD_SET_ADDRESS = 8'h21;
    localparam logic [7:0] CMD_ERASE_PAGE  = 8'h41;

    // Class request codes
    localparam logic [7:0] REQ_DETACH    = 8'd0;
    localparam logic [7:0] REQ_DNLOAD    = 8'd1;
    localparam logic [7:0] REQ_UPLOAD    = 8'd2;
    localparam logic [7:0] REQ_GETSTATUS = 8'd3;
    localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] REQ_GETSTATE  = 8'd5;
    localparam logic [7:0] REQ_ABORT     = 8'd6;

    // Reply lengths
    localparam logic [2:0] RLEN_NONE     = 3'd0;
    localparam logic [2:0] RLEN_STATE    = 3'd1;
    localparam logic [2:0] RLEN_STATUS   = 3'd6;

    // Shortest block-0 payload that carries a command
    localparam logic [15:0] CMD_MIN_LEN  = 16'd5;

    typedef enum logic [3:0] {
        ST_APP_DETACH    = 4'd1,
        ST_IDLE          = 4'd2,
        ST_DNLOAD_SYNC   = 4'd3,
        ST_DNBUSY        = 4'd4,
        ST_DNLOAD_IDLE   = 4'd5,
        ST_MANIFEST_SYNC = 4'd6,
        ST_MANIFEST      = 4'd7,
        ST_UPLOAD_IDLE   = 4'd9,
        ST_ERROR         = 4'd10
    } dfu_state_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ERASE   = 3'd1,
        STAT_UNKNOWN = 3'd2,
        STAT_ADDRESS = 3'd3,
        STAT_WRITE   = 3'd4,
        STAT_VERIFY  = 3'd5
    } dfu_status_t;

    typedef enum logic [1:0] {
        FOP_NONE    = 2'd0,
        FOP_ERASE   = 2'd1,
        FOP_PROGRAM = 2'd2
    } flash_op_t;

    // One incoming request
    typedef struct packed {
        logic        opcode;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] transfer_length;
        logic [7:0]  command_byte;
        logic [31:0] command_address;
        logic        erase_ok;
        logic        write_ok;
        logic        verify_ok;
    } dfursm_item_t;

    // Protocol context carried between requests
    typedef struct packed {
        dfu_state_t  proto;
        dfu_status_t status;
        logic [31:0] base_address;
        logic [15:0] current_block;
    } dfursm_ctx_t;

    // One reply
    typedef struct packed {
        logic        handled;
        logic [2:0]  reply_length;
        dfu_status_t reply_status;
        dfu_state_t  reply_state;
        flash_op_t   flash_op;
        logic [31:0] flash_address;
        logic [15:0] flash_length;
    } dfursm_result_t;

endpackage

FILE: rtl/core/dfursm_decode.sv
// Request decode: next protocol context and reply for one request
module dfursm_decode (
    input  dfursm_pkg::dfursm_item_t   item,
    input  dfursm_pkg::dfursm_ctx_t    ctx,
    input  logic [31:0]                flash_limit,
    output dfursm_pkg::dfursm_ctx_t    ctx_next,
    output dfursm_pkg::dfursm_result_t result
);
    import dfursm_pkg::*;

    logic [15:0]       blk_off;
    logic [PROD_W-1:0] blk_prod;
    logic [WA_W-1:0]   wa;
    logic [END_W-1:0]  wa_end;
    logic              out_of_range;
    logic [31:0]       page_addr;

    // Firmware block address and bounds check
    assign blk_off      = ctx.current_block - 16'd2;
    assign blk_prod     = PROD_W'(blk_off) * PROD_W'(TRANSFER_BYTES);
    assign wa           = WA_W'(ctx.base_address) + WA_W'(blk_prod);
    assign wa_end       = END_W'(wa) + END_W'(item.transfer_length);
    assign out_of_range = wa_end > END_W'(flash_limit);

    // Erase address rounded down to a page
    assign page_addr = item.command_address & ~(32'(PAGE_BYTES) - 32'd1);

    // Request handling
    always_comb
    begin
        ctx_next               = ctx;
        result.handled         = 1'b0;
        result.reply_length    = RLEN_NONE;
        result.flash_op        = FOP_NONE;
        result.flash_address   = '0;
        result.flash_length    = '0;

        if (!item.opcode)
        begin
            result.handled = 1'b1;
            unique case (item.request_code) inside
                REQ_DETACH:
                begin
                    ctx_next.proto  = ST_APP_DETACH;
                    ctx_next.status = STAT_OK;
                end
                REQ_DNLOAD:
                begin
                    if (item.transfer_length == '0)
                        ctx_next.proto = ST_MANIFEST_SYNC;
                    else
                    begin
                        ctx_next.current_block = item.request_value;
                        ctx_next.proto         = ST_DNLOAD_SYNC;
                    end
                    ctx_next.status = STAT_OK;
                end
                REQ_UPLOAD:
                begin
                    ctx_next.proto  = ST_UPLOAD_IDLE;
                    ctx_next.status = STAT_OK;
                end
                REQ_GETSTATUS:
                begin
                    case (ctx.proto)
                        ST_DNLOAD_SYNC:   ctx_next.proto = ST_DNBUSY;
                        ST_DNBUSY:        ctx_next.proto = ST_DNLOAD_IDLE;
                        ST_MANIFEST_SYNC: ctx_next.proto = ST_MANIFEST;
                        default:          ctx_next.proto = ctx.proto;
                    endcase
                    result.reply_length = RLEN_STATUS;
                end
                REQ_CLRSTATUS, REQ_ABORT:
                begin
                    ctx_next.proto  = ST_IDLE;
                    ctx_next.status = STAT_OK;
                end
                REQ_GETSTATE:
                    result.reply_length = RLEN_STATE;
                default:
                    result.handled = 1'b0;
            endcase
        end
        else if (ctx.current_block == '0)
        begin
            // Block 0: command payload
            if (item.transfer_length >= CMD_MIN_LEN)
            begin
                unique case (item.command_byte) inside
                    CMD_SET_ADDRESS:
                    begin
                        ctx_next.base_address = item.command_address;
                        ctx_next.status       = STAT_OK;
                    end
                    CMD_ERASE_PAGE:
                    begin
                        result.flash_op      = FOP_ERASE;
                        result.flash_address = page_addr;
                        if (!item.erase_ok)
                        begin
                            ctx_next.status = STAT_ERASE;
                            ctx_next.proto  = ST_ERROR;
                        end
                        else
                            ctx_next.status = STAT_OK;
                    end
                    default:
                    begin
                        ctx_next.status = STAT_UNKNOWN;
                        ctx_next.proto  = ST_ERROR;
                    end
                endcase
            end
        end
        else if (ctx.current_block != 16'd1 && item.transfer_length != '0)
        begin
            // Firmware block
            result.flash_address = wa[31:0];
            if (out_of_range)
            begin
                ctx_next.status = STAT_ADDRESS;
                ctx_next.proto  = ST_ERROR;
            end
            else
            begin
                result.flash_op     = FOP_PROGRAM;
                result.flash_length = item.transfer_length;
                if (!item.erase_ok)
                begin
                    ctx_next.status = STAT_ERASE;
                    ctx_next.proto  = ST_ERROR;
                end
                else if (!item.write_ok)
                begin
                    ctx_next.status = STAT_WRITE;
                    ctx_next.proto  = ST_ERROR;
                end
                else if (!item.verify_ok)
                begin
                    ctx_next.status = STAT_VERIFY;
                    ctx_next.proto  = ST_ERROR;
                end
                else
                    ctx_next.status = STAT_OK;
            end
        end

        result.reply_status = ctx_next.status;
        result.reply_state  = ctx_next.proto;
    end

endmodule

FILE: rtl/core/dfu_request_state_machine_unit.sv
// Replies are registered: a request is held in the input register, its reply in the
// result register. Throughput: one request per cycle while replies are taken; the two
// registers form a two-stage pipeline, and the protocol context updates as a request
// leaves the input register, so the request behind it already sees the new context.
// Reset: asynchronous, active low; state dfuIDLE, status ok, base address, block
// and flash end cleared, both stages empty.
`include "dfu_request_state_machine_unit_defines.svh"

// Top level: stream handshake, pipeline registers and protocol context
module dfu_request_state_machine_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: flash end address
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // request_code[7:0], request_value[23:8], transfer_length[39:24],
    // command_byte[47:40], command_address[79:48], erase_ok[80], write_ok[81],
    // verify_ok[82], zero[87:83]
    input  logic [87:0] s_tdata,
    // opcode[0]
    input  logic        s_tuser,
    // reply stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // handled[0], reply_length[3:1], reply_status[6:4], reply_state[10:7],
    // flash_op[12:11], flash_address[44:13], flash_length[60:45], zero[63:61]
    output logic [63:0] m_tdata
);
    import dfursm_pkg::*;

    dfursm_item_t   in_reg;
    logic           in_valid_reg;
    dfursm_result_t out_reg;
    logic           out_valid_reg;
    dfursm_ctx_t    ctx_reg;
    dfursm_ctx_t    ctx_next;
    dfursm_result_t result_next;
    logic [31:0]    flash_limit_reg;
    dfursm_item_t   item_in;
    logic           advance;
    logic           in_take;

    // Unpack the request
    always_comb
    begin
        item_in.opcode          = s_tuser;
        item_in.request_code    = s_tdata[7:0];
        item_in.request_value   = s_tdata[23:8];
        item_in.transfer_length = s_tdata[39:24];
        item_in.command_byte    = s_tdata[47:40];
        item_in.command_address = s_tdata[79:48];
        item_in.erase_ok        = s_tdata[80];
        item_in.write_ok        = s_tdata[81];
        item_in.verify_ok       = s_tdata[82];
    end

    // Pipeline flow control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    dfursm_decode u_decode (
        .item        (in_reg),
        .ctx         (ctx_reg),
        .flash_limit (flash_limit_reg),
        .ctx_next    (ctx_next),
        .result      (result_next)
    );

    // Control state, context and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            ctx_reg.proto         <= ST_IDLE;
            ctx_reg.status        <= STAT_OK;
            ctx_reg.base_address  <= '0;
            ctx_reg.current_block <= '0;
            flash_limit_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                flash_limit_reg <= cfg_wr_data;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= item_in;
        if (advance)
            out_reg <= result_next;
    end

    // Pack the reply
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.flash_length, out_reg.flash_address,
                       out_reg.flash_op, out_reg.reply_state, out_reg.reply_status,
                       out_reg.reply_length, out_reg.handled};

    // Checks
    `DFURSM_ASSERT_NEXT(a_advance_shows_reply, advance, out_valid_reg,
        "request left the input stage but no reply is shown")
    `DFURSM_ASSERT_NOW(a_no_overwrite, s_tready && in_valid_reg, advance,
        "input stage reloaded while still holding a request")
    `DFURSM_ASSERT_NOW(a_length_only_program,
        out_valid_reg && (out_reg.flash_op != FOP_PROGRAM), out_reg.flash_length == '0,
        "flash length set without a program command")
    `DFURSM_ASSERT_NOW(a_setup_no_flash, out_valid_reg && out_reg.handled,
        out_reg.flash_op == FOP_NONE,
        "setup request issued a flash command")

endmodule
